### rtl/core/cma_pkg.sv
// Shared types and constants for the confusion matrix accumulator.
// Holds the action codes, stream field layout and the counter bank control group.
// No dependencies; every other file of the block uses it.
`default_nettype none

package cma_pkg;

   localparam int NUM_CLASSES_DEF = 16;
   localparam int COUNT_WIDTH_DEF = 32;

   localparam int CLASS_W = 4;
   localparam int INDEX_W = 5;
   localparam int OUT_W   = 32;
   localparam int SPAN_W  = 5;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 112;
   localparam int RSP_TUSER_W = 1;

   localparam int REQ_TRUTH_LSB = 0;
   localparam int REQ_RETR_LSB  = REQ_TRUTH_LSB + CLASS_W;
   localparam int REQ_ROW_LSB   = REQ_RETR_LSB + CLASS_W;
   localparam int REQ_COL_LSB   = REQ_ROW_LSB + INDEX_W;

   localparam int RSP_CELL_LSB    = 0;
   localparam int RSP_TSEEN_LSB   = RSP_CELL_LSB + OUT_W;
   localparam int RSP_RSEEN_LSB   = RSP_TSEEN_LSB + SPAN_W;
   localparam int RSP_CORRECT_LSB = RSP_RSEEN_LSB + SPAN_W;
   localparam int RSP_TOTAL_LSB   = RSP_CORRECT_LSB + OUT_W;
   localparam int RSP_PAD_W       = RSP_TDATA_W - (RSP_TOTAL_LSB + OUT_W);

   typedef enum logic [REQ_TUSER_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_RECORD = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   typedef struct packed {
      logic clr;
      logic rd;
      logic inc;
   } bank_ctl_type;

endpackage

`default_nettype wire

### rtl/core/cma_count_bank.sv
// Saturating counter bank held in a synchronous memory with a registered read.
// Reads, increments and writes back with forwarding, and sweeps itself to zero.
// Depends on cma_pkg for the control group type.
`default_nettype none

module cma_count_bank #(
   parameter int DEPTH = cma_pkg::NUM_CLASSES_DEF,
   parameter int WIDTH = cma_pkg::COUNT_WIDTH_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cma_pkg::bank_ctl_type ctl,
   input  wire logic [AW-1:0]        addr,
   output logic      [WIDTH-1:0]     value,
   output logic                      busy
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem [DEPTH];

   logic [AW-1:0]    rd_addr_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]    wr_addr_ff;
   logic [WIDTH-1:0] wr_data_ff;
   logic             fwd_valid_ff, fwd_valid_in;
   logic             busy_ff, busy_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic             hit;
   logic [WIDTH-1:0] inc_value;

   assign hit       = fwd_valid_ff && (wr_addr_ff == rd_addr_ff);
   assign value     = hit ? wr_data_ff : rd_data_ff;
   assign inc_value = (&value) ? value : value + WIDTH'(1);
   assign busy      = busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      sweep_in     = sweep_ff;
      fwd_valid_in = fwd_valid_ff || busy_ff || ctl.inc;
      if (ctl.clr) begin
         busy_in  = 1'b1;
         sweep_in = '0;
      end else if (busy_ff) begin
         if (sweep_ff == LAST) begin
            busy_in = 1'b0;
         end
         sweep_in = sweep_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         sweep_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         sweep_ff     <= sweep_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rd_addr_ff <= addr;
         rd_data_ff <= mem[addr];
      end
      if (busy_ff) begin
         mem[sweep_ff] <= '0;
         wr_addr_ff    <= sweep_ff;
         wr_data_ff    <= '0;
      end else if (ctl.inc) begin
         mem[rd_addr_ff] <= inc_value;
         wr_addr_ff      <= rd_addr_ff;
         wr_data_ff      <= inc_value;
      end
   end

endmodule

`default_nettype wire

### rtl/core/confusion_matrix_accumulator.sv
// An accepted transaction is registered in stage one and then in the result registers.
// Throughput: one record, read or unused code per cycle while results are taken.
// A clear, and the release of reset, start a sweep over the NUM_CLASSES*NUM_CLASSES
// cells (256 by default) of the cell memory, during which no transaction is accepted.
// The sweep writes its zeros through the single write port of the cell counter memory.
// Reset is synchronous and active high; the scalar totals and spans clear at once.
`default_nettype none

module confusion_matrix_accumulator #(
   parameter int NUM_CLASSES = cma_pkg::NUM_CLASSES_DEF,
   parameter int COUNT_WIDTH = cma_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // truth_class, retrieved_class, read_row, read_col
   input  wire logic [cma_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action
   input  wire logic [cma_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // cell_count, true_classes_seen, retrieved_classes_seen, correct_count, sample_total
   output logic      [cma_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // bad_class_flag
   output logic      [cma_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   import cma_pkg::*;

   localparam int CELLS   = NUM_CLASSES * NUM_CLASSES;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int ROW_AW  = $clog2(NUM_CLASSES);
   localparam logic [6:0] NCLS = 7'(NUM_CLASSES);

   function automatic logic [OUT_W-1:0] clamp32(input logic [COUNT_WIDTH-1:0] v);
      return (|(v >> OUT_W)) ? '1 : OUT_W'(v);
   endfunction

   action_type         in_act;
   logic [CLASS_W-1:0] in_truth, in_retr;
   logic [INDEX_W-1:0] in_row, in_col, row_sel, col_sel;
   logic               is_rec, in_ok, accept;
   logic [CELL_AW-1:0] cell_addr;
   bank_ctl_type       bank_ctl;
   logic               cell_busy, row_busy, col_busy, busy;
   logic [COUNT_WIDTH-1:0] cell_val, row_val, col_val;

   logic               s1_valid_ff, s1_valid_in, s1_adv;
   action_type         s1_act_ff;
   logic               s1_ok_ff, s1_bad_ff, s1_diag_ff;
   logic [CLASS_W-1:0] s1_truth_ff, s1_retr_ff;
   logic [INDEX_W-1:0] s1_row_ff, s1_col_ff;

   logic [COUNT_WIDTH-1:0] grand_ff, grand_in, grand_upd;
   logic [COUNT_WIDTH-1:0] diag_ff, diag_in, diag_upd;
   logic [SPAN_W-1:0]      tspan_ff, tspan_in, tspan_upd;
   logic [SPAN_W-1:0]      rspan_ff, rspan_in, rspan_upd;
   logic [SPAN_W-1:0]      t_next, r_next;
   logic [COUNT_WIDTH-1:0] cell_sel;
   logic                   row_hi, col_hi, over;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_cell_ff, rsp_correct_ff, rsp_total_ff;
   logic [SPAN_W-1:0] rsp_tseen_ff, rsp_rseen_ff;
   logic              rsp_bad_ff;

   assign in_act   = action_type'(req_tuser);
   assign in_truth = req_tdata[REQ_TRUTH_LSB +: CLASS_W];
   assign in_retr  = req_tdata[REQ_RETR_LSB +: CLASS_W];
   assign in_row   = req_tdata[REQ_ROW_LSB +: INDEX_W];
   assign in_col   = req_tdata[REQ_COL_LSB +: INDEX_W];
   assign is_rec   = (in_act == ACT_RECORD);
   assign in_ok    = (7'(in_truth) < NCLS) && (7'(in_retr) < NCLS);
   assign row_sel  = is_rec ? INDEX_W'(in_truth) : in_row;
   assign col_sel  = is_rec ? INDEX_W'(in_retr) : in_col;
   assign cell_addr = CELL_AW'(row_sel) * CELL_AW'(NUM_CLASSES) + CELL_AW'(col_sel);

   assign busy       = cell_busy || row_busy || col_busy;
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;

   assign bank_ctl.clr = accept && (in_act == ACT_CLEAR);
   assign bank_ctl.rd  = accept && (is_rec || (in_act == ACT_READ));
   assign bank_ctl.inc = s1_adv && s1_ok_ff;

   cma_count_bank #(.DEPTH(CELLS), .WIDTH(COUNT_WIDTH)) u_cell_bank (
      .clock (clock),
      .reset (reset),
      .ctl   (bank_ctl),
      .addr  (cell_addr),
      .value (cell_val),
      .busy  (cell_busy)
   );

   cma_count_bank #(.DEPTH(NUM_CLASSES), .WIDTH(COUNT_WIDTH)) u_row_bank (
      .clock (clock),
      .reset (reset),
      .ctl   (bank_ctl),
      .addr  (ROW_AW'(row_sel)),
      .value (row_val),
      .busy  (row_busy)
   );

   cma_count_bank #(.DEPTH(NUM_CLASSES), .WIDTH(COUNT_WIDTH)) u_col_bank (
      .clock (clock),
      .reset (reset),
      .ctl   (bank_ctl),
      .addr  (ROW_AW'(col_sel)),
      .value (col_val),
      .busy  (col_busy)
   );

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff   <= in_act;
         s1_ok_ff    <= is_rec && in_ok;
         s1_bad_ff   <= is_rec && !in_ok;
         s1_diag_ff  <= (in_truth == in_retr);
         s1_truth_ff <= in_truth;
         s1_retr_ff  <= in_retr;
         s1_row_ff   <= in_row;
         s1_col_ff   <= in_col;
      end
   end

   assign t_next = SPAN_W'(s1_truth_ff) + SPAN_W'(1);
   assign r_next = SPAN_W'(s1_retr_ff) + SPAN_W'(1);

   always_comb begin
      grand_upd = grand_ff;
      diag_upd  = diag_ff;
      tspan_upd = tspan_ff;
      rspan_upd = rspan_ff;
      if (s1_ok_ff) begin
         grand_upd = (&grand_ff) ? grand_ff : grand_ff + COUNT_WIDTH'(1);
         if (s1_diag_ff && !(&diag_ff)) begin
            diag_upd = diag_ff + COUNT_WIDTH'(1);
         end
         if (t_next > tspan_ff) begin
            tspan_upd = t_next;
         end
         if (r_next > rspan_ff) begin
            rspan_upd = r_next;
         end
      end
   end

   always_comb begin
      grand_in = grand_ff;
      diag_in  = diag_ff;
      tspan_in = tspan_ff;
      rspan_in = rspan_ff;
      if (bank_ctl.clr) begin
         grand_in = '0;
         diag_in  = '0;
         tspan_in = '0;
         rspan_in = '0;
      end else if (s1_adv) begin
         grand_in = grand_upd;
         diag_in  = diag_upd;
         tspan_in = tspan_upd;
         rspan_in = rspan_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grand_ff <= '0;
         diag_ff  <= '0;
         tspan_ff <= '0;
         rspan_ff <= '0;
      end else begin
         grand_ff <= grand_in;
         diag_ff  <= diag_in;
         tspan_ff <= tspan_in;
         rspan_ff <= rspan_in;
      end
   end

   assign row_hi = (7'(s1_row_ff) == NCLS);
   assign col_hi = (7'(s1_col_ff) == NCLS);
   assign over   = (7'(s1_row_ff) > NCLS) || (7'(s1_col_ff) > NCLS);

   always_comb begin
      cell_sel = '0;
      case (s1_act_ff)
         ACT_READ: begin
            if (over) begin
               cell_sel = '0;
            end else if (row_hi && col_hi) begin
               cell_sel = grand_ff;
            end else if (row_hi) begin
               cell_sel = col_val;
            end else if (col_hi) begin
               cell_sel = row_val;
            end else begin
               cell_sel = cell_val;
            end
         end
         default: begin
            cell_sel = '0;
         end
      endcase
   end

   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_cell_ff    <= clamp32(cell_sel);
         rsp_tseen_ff   <= tspan_upd;
         rsp_rseen_ff   <= rspan_upd;
         rsp_correct_ff <= clamp32(diag_upd);
         rsp_total_ff   <= clamp32(grand_upd);
         rsp_bad_ff     <= s1_bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_total_ff, rsp_correct_ff,
                        rsp_rseen_ff, rsp_tseen_ff, rsp_cell_ff};
   assign rsp_tuser  = rsp_bad_ff;

endmodule

`default_nettype wire

### rtl/core/cma_checker.sv
// Port-level checks for the confusion matrix accumulator, bound to its top level.
// Depends on cma_pkg for the action codes and the result field layout.
`default_nettype none

module cma_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [cma_pkg::REQ_TUSER_W-1:0] req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [cma_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [cma_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   import cma_pkg::*;

   ap_reset_sweep : assert property (@(posedge clock) reset |=> !req_tready)
      else $error("Input accepted while the post-reset sweep should be running.");

   ap_clear_sweep : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_TUSER_W'(ACT_CLEAR)) |=> !req_tready)
      else $error("Input accepted directly after a clear transaction.");

   ap_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result changed or was dropped.");

   ap_bad_no_cell : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[RSP_CELL_LSB +: OUT_W] == '0))
      else $error("Rejected record returned a nonzero cell count.");

   ap_correct_le_total : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_CORRECT_LSB +: OUT_W] <= rsp_tdata[RSP_TOTAL_LSB +: OUT_W]))
      else $error("Correct count exceeds the sample total.");

endmodule

bind confusion_matrix_accumulator cma_checker u_cma_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for confusion_matrix_accumulator.
// It keeps its own model of the count store in a scoreboard class and drives both
// stream ports with random idle gaps. It depends on cma_pkg and the block's RTL.

module tb;
   import cma_pkg::*;

   localparam int NUM_CLASSES  = NUM_CLASSES_DEF;
   localparam int RANDOM_ITEMS = 450;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 120;
   localparam int PAUSE_AT     = 320;
   localparam int MAX_REPORTS  = 10;
   localparam logic [REQ_TUSER_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic              bad;
      logic [OUT_W-1:0]  total;
      logic [OUT_W-1:0]  correct;
      logic [SPAN_W-1:0] rseen;
      logic [SPAN_W-1:0] tseen;
      logic [OUT_W-1:0]  cell_cnt;
   } matrix_result_type;

   class matrix_scoreboard;
      logic [OUT_W-1:0]  cells[NUM_CLASSES*NUM_CLASSES];
      logic [OUT_W-1:0]  row_sum[NUM_CLASSES];
      logic [OUT_W-1:0]  col_sum[NUM_CLASSES];
      logic [OUT_W-1:0]  grand;
      logic [OUT_W-1:0]  diag;
      logic [SPAN_W-1:0] true_span;
      logic [SPAN_W-1:0] retr_span;
      matrix_result_type expected_q[$];
      int                failures;

      function new();
         failures = 0;
         clear_store();
      endfunction

      function void clear_store();
         foreach (cells[i]) cells[i] = '0;
         foreach (row_sum[i]) row_sum[i] = '0;
         foreach (col_sum[i]) col_sum[i] = '0;
         grand = '0;
         diag = '0;
         true_span = '0;
         retr_span = '0;
      endfunction

      function logic [OUT_W-1:0] bump(logic [OUT_W-1:0] v);
         return (v == '1) ? v : v + OUT_W'(1);
      endfunction

      function logic [OUT_W-1:0] cell_at(logic [INDEX_W-1:0] row, logic [INDEX_W-1:0] col);
         if (row > NUM_CLASSES || col > NUM_CLASSES) return '0;
         if (row == NUM_CLASSES && col == NUM_CLASSES) return grand;
         if (row == NUM_CLASSES) return col_sum[col];
         if (col == NUM_CLASSES) return row_sum[row];
         return cells[int'(row) * NUM_CLASSES + int'(col)];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [REQ_TUSER_W-1:0] act, logic [REQ_TDATA_W-1:0] data);
         logic [CLASS_W-1:0] t;
         logic [CLASS_W-1:0] r;
         logic [SPAN_W-1:0]  t_next;
         logic [SPAN_W-1:0]  r_next;
         matrix_result_type  res;
         int                 k;
         t = data[REQ_TRUTH_LSB +: CLASS_W];
         r = data[REQ_RETR_LSB +: CLASS_W];
         res = '0;
         case (act)
            ACT_CLEAR: begin
               clear_store();
            end
            ACT_RECORD: begin
               if (t >= NUM_CLASSES || r >= NUM_CLASSES) begin
                  res.bad = 1'b1;
               end else begin
                  k = int'(t) * NUM_CLASSES + int'(r);
                  cells[k] = bump(cells[k]);
                  row_sum[t] = bump(row_sum[t]);
                  col_sum[r] = bump(col_sum[r]);
                  grand = bump(grand);
                  if (t == r) diag = bump(diag);
                  t_next = SPAN_W'(t) + SPAN_W'(1);
                  r_next = SPAN_W'(r) + SPAN_W'(1);
                  if (t_next > true_span) true_span = t_next;
                  if (r_next > retr_span) retr_span = r_next;
               end
            end
            ACT_READ: begin
               res.cell_cnt = cell_at(data[REQ_ROW_LSB +: INDEX_W],
                                      data[REQ_COL_LSB +: INDEX_W]);
            end
            default: ;
         endcase
         res.tseen = true_span;
         res.rseen = retr_span;
         res.correct = diag;
         res.total = grand;
         expected_q.push_back(res);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data, logic bad);
         matrix_result_type got;
         matrix_result_type want;
         got.cell_cnt = data[RSP_CELL_LSB +: OUT_W];
         got.tseen = data[RSP_TSEEN_LSB +: SPAN_W];
         got.rseen = data[RSP_RSEEN_LSB +: SPAN_W];
         got.correct = data[RSP_CORRECT_LSB +: OUT_W];
         got.total = data[RSP_TOTAL_LSB +: OUT_W];
         got.bad = bad;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected result transaction cell=%0d total=%0d",
                        $realtime, got.cell_cnt, got.total);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("%0t: mismatch", $realtime);
               $display("   expected cell=%0d tseen=%0d rseen=%0d correct=%0d total=%0d bad=%0b",
                        want.cell_cnt, want.tseen, want.rseen, want.correct, want.total,
                        want.bad);
               $display("   actual   cell=%0d tseen=%0d rseen=%0d correct=%0d total=%0d bad=%0b",
                        got.cell_cnt, got.tseen, got.rseen, got.correct, got.total, got.bad);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = ACT_READ;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   matrix_scoreboard sb = new();
   int item_no = 0;
   int idle_cycles = 0;

   confusion_matrix_accumulator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser[0]);
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_request(
      logic [CLASS_W-1:0] truth, logic [CLASS_W-1:0] retr,
      logic [INDEX_W-1:0] row, logic [INDEX_W-1:0] col);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[REQ_TRUTH_LSB +: CLASS_W] = truth;
      d[REQ_RETR_LSB +: CLASS_W] = retr;
      d[REQ_ROW_LSB +: INDEX_W] = row;
      d[REQ_COL_LSB +: INDEX_W] = col;
      return d;
   endfunction

   // Reads favor the busy low classes and the totals so that most of them see nonzero counts.
   function automatic logic [INDEX_W-1:0] pick_index();
      int k;
      k = $urandom_range(0, 9);
      if (k < 4) return INDEX_W'($urandom_range(0, 3));
      if (k < 6) return INDEX_W'(NUM_CLASSES);
      if (k < 9) return INDEX_W'($urandom_range(0, NUM_CLASSES - 1));
      return INDEX_W'($urandom_range(0, 31));
   endfunction

   task automatic send_item(input logic [REQ_TUSER_W-1:0] act,
                            input logic [REQ_TDATA_W-1:0] data);
      int gap;
      if ((item_no >= 140 && item_no < 230) || (item_no % 100) < 15) gap = 0;
      else gap = $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_no++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin : result_sink
      int gap;
      int beats;
      beats = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (beats == HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = ((beats % 90) < 20) ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         beats++;
      end
   end

   initial begin : stimulus
      logic [REQ_TUSER_W-1:0] act;
      logic [CLASS_W-1:0]     truth;
      logic [CLASS_W-1:0]     retr;
      int                     pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_READ, pack_request(0, 0, 0, 0));
      send_item(ACT_READ, pack_request(0, 0, NUM_CLASSES, NUM_CLASSES));
      send_item(ACT_UNUSED, pack_request(15, 15, 31, 31));
      send_item(ACT_RECORD, pack_request(0, 0, 0, 0));
      send_item(ACT_RECORD, pack_request(15, 15, 31, 31));
      send_item(ACT_RECORD, pack_request(0, 15, 0, 0));
      send_item(ACT_RECORD, pack_request(15, 0, 31, 31));
      send_item(ACT_RECORD, pack_request(15, 15, 0, 0));
      send_item(ACT_READ, pack_request(15, 15, 15, 15));
      send_item(ACT_READ, pack_request(0, 0, NUM_CLASSES, NUM_CLASSES));
      send_item(ACT_READ, pack_request(0, 0, NUM_CLASSES, 15));
      send_item(ACT_READ, pack_request(0, 0, 15, NUM_CLASSES));
      send_item(ACT_READ, pack_request(0, 0, NUM_CLASSES, 0));
      send_item(ACT_READ, pack_request(0, 0, 0, NUM_CLASSES));
      send_item(ACT_READ, pack_request(15, 15, 31, 31));
      send_item(ACT_READ, pack_request(0, 0, NUM_CLASSES + 1, 3));
      send_item(ACT_READ, pack_request(0, 0, 3, NUM_CLASSES + 1));
      send_item(ACT_UNUSED, pack_request(7, 9, 1, 2));
      send_item(ACT_CLEAR, pack_request(15, 15, 31, 31));
      send_item(ACT_READ, pack_request(0, 0, NUM_CLASSES, NUM_CLASSES));
      send_item(ACT_RECORD, pack_request(7, 9, 0, 0));
      send_item(ACT_READ, pack_request(0, 0, 7, 9));
      send_item(ACT_CLEAR, pack_request(0, 0, 0, 0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) act = ACT_CLEAR;
         else if (pick < 55) act = ACT_RECORD;
         else if (pick < 93) act = ACT_READ;
         else act = ACT_UNUSED;
         truth = ($urandom_range(0, 1) != 0) ? CLASS_W'($urandom_range(0, 3))
                                             : CLASS_W'($urandom_range(0, 15));
         retr = ($urandom_range(0, 1) != 0) ? CLASS_W'($urandom_range(0, 3))
                                            : CLASS_W'($urandom_range(0, 15));
         send_item(act, pack_request(truth, retr, pick_index(), pick_index()));
         if (item_no == PAUSE_AT) wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
